[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/core/pcxrle_pkg.sv]
package pcxrle_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LINE_BYTES   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [7:0] MARKER_MASK = 8'hC0;
	localparam logic [7:0] COUNT_MASK  = 8'h3F;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic step;
		logic in_run;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic cont;
	} dp_status_t;

endpackage

[rtl/core/pcxrle_ctrl.sv]
module pcxrle_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  pcxrle_pkg::dp_status_t status,
	output logic                   s_tready,
	output pcxrle_pkg::dp_cmd_t    cmd
);

	pcxrle_pkg::state_t state_q, state_d;

	always_comb begin
		cmd.in_run = (state_q == pcxrle_pkg::ST_RUN);
		s_tready   = (state_q == pcxrle_pkg::ST_IDLE) && status.out_free;
		cmd.take   = s_tvalid && s_tready;
		cmd.step   = (state_q == pcxrle_pkg::ST_RUN) && status.out_free;
		state_d    = state_q;
		unique case (state_q)
			pcxrle_pkg::ST_IDLE: begin
				if (cmd.take && status.cont) state_d = pcxrle_pkg::ST_RUN;
			end
			pcxrle_pkg::ST_RUN: begin
				if (cmd.step && !status.cont) state_d = pcxrle_pkg::ST_IDLE;
			end
			default: state_d = pcxrle_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcxrle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/pcxrle_datapath.sv]
`include "assert_macros.svh"

module pcxrle_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pcxrle_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [pcxrle_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [7:0]                            in_byte,
	input  logic                                  in_final,
	input  pcxrle_pkg::dp_cmd_t                   cmd,
	output pcxrle_pkg::dp_status_t                status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [7:0]                            out_pixel,
	output logic [15:0]                           out_column,
	output logic [15:0]                           out_row,
	output logic                                  out_last,
	output logic                                  out_error
);

	logic [15:0] wd_q, lb_q, ht_q;
	logic [15:0] lp_q, row_q, lp_d, row_d;
	logic        pend_q, pend_d;
	logic [5:0]  rlen_q, rlen_d, cnt_q, cnt_d;
	logic [7:0]  byte_q;
	logic        fin_q;

	logic        o_valid_q;
	logic [7:0]  o_pixel_q;
	logic [15:0] o_col_q, o_row_q;
	logic        o_last_q, o_err_q;

	logic        wrap, done, marker, data_b, is_step, emit, last_s, cont, err_res, go;
	logic        at_end, fin_s;
	logic [15:0] lp_e, row_e, p_s, row_s;
	logic [5:0]  c_in, c_s;
	logic [7:0]  b_s;
	logic [16:0] p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q <= 16'd1;
			lb_q <= 16'd1;
			ht_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcxrle_pkg::REG_IMAGE_WIDTH:  wd_q <= cfg_wdata;
				pcxrle_pkg::REG_LINE_BYTES:   lb_q <= cfg_wdata;
				pcxrle_pkg::REG_IMAGE_HEIGHT: ht_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		// row closed first if the position already reached the line end
		wrap   = (lb_q != 16'd0) && (lp_q >= lb_q);
		lp_e   = wrap ? 16'd0 : lp_q;
		row_e  = wrap ? row_q + 16'd1 : row_q;
		done   = (lb_q == 16'd0) || (row_e >= ht_q);
		marker = (in_byte & pcxrle_pkg::MARKER_MASK) == pcxrle_pkg::MARKER_MASK;
		data_b = pend_q || !marker;
		c_in   = pend_q ? rlen_q : 6'd1;

		p_s   = cmd.in_run ? lp_q   : lp_e;
		row_s = cmd.in_run ? row_q  : row_e;
		c_s   = cmd.in_run ? cnt_q  : c_in;
		b_s   = cmd.in_run ? byte_q : in_byte;
		fin_s = cmd.in_run ? fin_q  : in_final;

		is_step = cmd.in_run || (!done && data_b && (c_in != 6'd0));
		p1      = {1'b0, p_s} + 17'd1;
		at_end  = p1 >= {1'b0, lb_q};
		emit    = is_step && (p_s < wd_q);
		last_s  = (c_s == 6'd1) || at_end || (p1 >= {1'b0, wd_q});
		cont    = is_step && (c_s > 6'd1) && !at_end;
		err_res = !cmd.in_run && !done && !data_b && in_final;
		go      = cmd.take || cmd.step;

		status.out_free = !o_valid_q || out_ready;
		status.cont     = cont;

		lp_d   = lp_q;
		row_d  = row_q;
		pend_d = pend_q;
		rlen_d = rlen_q;
		cnt_d  = cnt_q;
		if (go) begin
			if (!cmd.in_run) begin
				lp_d  = lp_e;
				row_d = row_e;
			end
			if (cmd.in_run || (!done && data_b)) begin
				pend_d = 1'b0;
				rlen_d = 6'd0;
			end
			if (!cmd.in_run && !done && !data_b && !in_final) begin
				pend_d = 1'b1;
				rlen_d = in_byte[5:0] & pcxrle_pkg::COUNT_MASK[5:0];
			end
			if (is_step) begin
				if (cont) begin
					lp_d  = p1[15:0];
					row_d = row_s;
					cnt_d = c_s - 6'd1;
				end else if (at_end) begin
					lp_d  = 16'd0;
					row_d = row_s + 16'd1;
				end else begin
					lp_d  = p1[15:0];
				end
			end
			if (fin_s && !cont) begin
				lp_d   = 16'd0;
				row_d  = 16'd0;
				pend_d = 1'b0;
				rlen_d = 6'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q   <= 16'd0;
			row_q  <= 16'd0;
			pend_q <= 1'b0;
			rlen_q <= 6'd0;
			cnt_q  <= 6'd0;
		end else begin
			lp_q   <= lp_d;
			row_q  <= row_d;
			pend_q <= pend_d;
			rlen_q <= rlen_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && cont) begin
			byte_q <= in_byte;
			fin_q  <= in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (go && (emit || err_res)) begin
			o_valid_q <= 1'b1;
		end else if (out_ready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && (emit || err_res)) begin
			o_pixel_q <= err_res ? 8'd0 : b_s;
			o_col_q   <= p_s;
			o_row_q   <= row_s;
			o_last_q  <= err_res ? 1'b1 : last_s;
			o_err_q   <= err_res;
		end
	end

	assign out_valid  = o_valid_q;
	assign out_pixel  = o_pixel_q;
	assign out_column = o_col_q;
	assign out_row    = o_row_q;
	assign out_last   = o_last_q;
	assign out_error  = o_err_q;

	`ASSERT_CLK(a_run_count_nonzero, cmd.in_run |-> (cnt_q != 6'd0), "run with zero count")
	`ASSERT_CLK(a_run_inside_line, cmd.in_run |-> (lp_q < lb_q), "run past line end")
	`ASSERT_CLK(a_pixel_visible, (o_valid_q && !o_err_q) |-> (o_col_q < wd_q),
		"pixel outside visible width")

endmodule

[rtl/core/pcx_rle_row_decoder.sv]
// pcx 8-bit run-length row decoder
// input stream (s_*): one encoded pixel byte per request, taken from the
//   byte after the 128-byte header; s_tlast marks the final byte of the file
// output stream (m_*): one decoded pixel per request with its column and row;
//   m_tlast flags the final pixel caused by one input byte, m_tuser flags the
//   error result for a file that ends on a run marker
// configuration: cfg_we writes cfg_wdata to register cfg_index (0 image width, 1 bytes
//   per line, 2 image height); the user writes only while idle, unenforced by the block
// throughput: a literal byte or a marker byte is done as it is taken; a run of n
//   repeats holds off the input while the position counter walks n line positions,
//   one per cycle while the output has room, cut short at the end of the line
// latency: a pixel shows on m_* the cycle after its position is decoded,
//   through the single output register
// stall: while m_tready is low and a pixel waits, decoding halts and the
//   input is held off; a new byte is taken in the cycle the waiting pixel leaves
// reset: position, row and pending run clear, all three registers go to 1;
//   after the final byte the same position state clears again
`include "assert_macros.svh"

module pcx_rle_row_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pcxrle_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [pcxrle_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // data_byte[7:0]
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [39:0]                       m_tdata,  // pixel[7:0], column[23:8], row[39:24]
	output logic                              m_tlast,
	output logic                              m_tuser   // error
);

	pcxrle_pkg::dp_cmd_t    cmd;
	pcxrle_pkg::dp_status_t status;

	logic [7:0]  pixel;
	logic [15:0] column, row;

	// sequencer: idle accepts bytes, run walks the repeat count
	pcxrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.status   (status),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	// position counters, run state, registers and output register
	pcxrle_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (s_tdata),
		.in_final   (s_tlast),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_pixel  (pixel),
		.out_column (column),
		.out_row    (row),
		.out_last   (m_tlast),
		.out_error  (m_tuser)
	);

	// pack the output fields, first field lowest
	assign m_tdata = {row, column, pixel};

	// a byte is only taken when its result has room in the output register
	`ASSERT_CLK(a_take_needs_room, s_tready |-> (!m_tvalid || m_tready),
		"input taken while output blocked")
	// an error result is a lone zero pixel closing its byte
	`ASSERT_CLK(a_error_shape, (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[7:0] == 8'd0)),
		"malformed error result")

endmodule

[tb/pcx_rle_row_decoder_test.sv]
module pcx_rle_row_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	// one decoded pixel as it leaves the block
	typedef struct packed {
		logic [7:0]  pixel;
		logic [15:0] column;
		logic [15:0] row;
		logic        last;
		logic        err;
	} pixel_t;

	// a directed step either feeds a byte or rewrites the image geometry
	typedef enum logic {STEP_BYTE, STEP_GEOMETRY} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		logic [7:0]  data;
		logic        eod;
		bit          typed;   // known carries the one pixel this byte must give
		pixel_t      known;
		logic [15:0] width;
		logic [15:0] lbytes;
		logic [15:0] height;
	} script_step_t;

	localparam int SETTLE_CYCLES = 80;  // a full 63-step run plus the output register
	localparam int IDLE_PCT      = 20;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [pcxrle_pkg::REG_IDX_W-1:0] cfg_index = pcxrle_pkg::REG_IMAGE_WIDTH;
	logic [pcxrle_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [7:0]                       s_tdata = '0;   // data_byte[7:0]
	logic                             s_tlast = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [39:0]                      m_tdata;        // pixel[7:0], column[23:8], row[39:24]
	logic                             m_tlast;
	logic                             m_tuser;        // error

	// geometry as the block should currently hold it
	logic [15:0] cur_width = 16'd1;
	logic [15:0] cur_lbytes = 16'd1;
	logic [15:0] cur_height = 16'd1;

	// decoder position state
	logic [15:0] line_pos = '0;
	logic [15:0] row_idx = '0;
	logic        run_pend = 1'b0;
	logic [5:0]  run_len = '0;

	pixel_t decoded[$];         // pixels caused by the byte just taken
	pixel_t pending_pixels[$];  // pixels still owed by the block, oldest first
	pixel_t seen;
	pixel_t wanted;

	int  failures = 0;
	int  bytes_sent = 0;   // bytes taken by the block, ignored ones included
	int  hold_left = 0;    // cycles the pixel side still holds off
	bit  no_idle = 1'b0;   // both sides run flat out while set

	pcx_rle_row_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs or loses pixels
	initial begin
		#5_000_000;
		$display("pcx_rle_row_decoder regression: fail");
		$finish;
	end

	// works out the pixels one encoded byte gives and advances the position state
	task automatic decode_pcx_byte(input logic [7:0] b, input logic eod);
		int     count;
		pixel_t px;
		decoded.delete();
		// a row left full by a geometry change closes before anything else
		if (cur_lbytes != 0 && line_pos >= cur_lbytes) begin
			line_pos = '0;
			row_idx = row_idx + 16'd1;
		end
		if (cur_lbytes == 0 || row_idx >= cur_height) begin
			// image complete, byte has no effect
		end else if (run_pend ||
				(b & pcxrle_pkg::MARKER_MASK) != pcxrle_pkg::MARKER_MASK) begin
			count = run_pend ? int'(run_len) : 1;
			run_pend = 1'b0;
			run_len = '0;
			// repeats stop at the end of the line, padding positions give nothing
			while (count > 0 && line_pos < cur_lbytes) begin
				if (line_pos < cur_width) begin
					px.pixel = b;
					px.column = line_pos;
					px.row = row_idx;
					px.last = 1'b0;
					px.err = 1'b0;
					decoded.push_back(px);
				end
				line_pos = line_pos + 16'd1;
				count--;
			end
			if (line_pos >= cur_lbytes) begin
				line_pos = '0;
				row_idx = row_idx + 16'd1;
			end
			if (decoded.size() > 0)
				decoded[decoded.size()-1].last = 1'b1;
		end else if (eod) begin
			// file ends on a run marker
			px.pixel = '0;
			px.column = line_pos;
			px.row = row_idx;
			px.last = 1'b1;
			px.err = 1'b1;
			decoded.push_back(px);
		end else begin
			run_pend = 1'b1;
			run_len = b[5:0] & pcxrle_pkg::COUNT_MASK[5:0];
		end
		// final byte rewinds the position state, geometry stays
		if (eod) begin
			line_pos = '0;
			row_idx = '0;
			run_pend = 1'b0;
			run_len = '0;
		end
	endtask

	// offers one byte, with random gaps before it, and books its pixels once taken
	task automatic send_byte(input logic [7:0] data, input logic eod, input bit typed = 1'b0,
			input pixel_t known = '0);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= eod;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		decode_pcx_byte(data, eod);
		if (typed)
			pending_pixels.push_back(known);
		else
			foreach (decoded[i])
				pending_pixels.push_back(decoded[i]);
	endtask

	// drops the input, waits for every owed pixel, then lets a long run finish
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all three registers on back-to-back cycles
	task automatic set_geometry(input logic [15:0] w, input logic [15:0] lb, input logic [15:0] h);
		cfg_we <= 1'b1;
		cfg_index <= pcxrle_pkg::REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= pcxrle_pkg::REG_LINE_BYTES;
		cfg_wdata <= lb;
		@(posedge clk);
		cfg_index <= pcxrle_pkg::REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_width = w;
		cur_lbytes = lb;
		cur_height = h;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// pixel side: check each pixel taken, then choose the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.pixel = m_tdata[7:0];
			seen.column = m_tdata[23:8];
			seen.row = m_tdata[39:24];
			seen.last = m_tlast;
			seen.err = m_tuser;
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel not expected, expected none got %h col %0d row %0d last %b err %b",
					$time, seen.pixel, seen.column, seen.row, seen.last, seen.err);
				failures++;
			end else begin
				wanted = pending_pixels.pop_front();
				check_field("pixel", 16'(wanted.pixel), 16'(seen.pixel));
				check_field("column", wanted.column, seen.column);
				check_field("row", wanted.row, seen.row);
				check_field("last", 16'(wanted.last), 16'(seen.last));
				check_field("error", 16'(wanted.err), 16'(seen.err));
			end
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic script_step_t byte_step(input logic [7:0] d, input logic eod);
		script_step_t s;
		s.kind = STEP_BYTE;
		s.data = d;
		s.eod = eod;
		s.typed = 1'b0;
		s.known = '0;
		s.width = '0;
		s.lbytes = '0;
		s.height = '0;
		return s;
	endfunction

	function automatic script_step_t known_step(input logic [7:0] d, input logic eod,
			input logic [7:0] pix, input logic [15:0] col, input logic [15:0] row, input logic err);
		script_step_t s;
		s = byte_step(d, eod);
		s.typed = 1'b1;
		s.known.pixel = pix;
		s.known.column = col;
		s.known.row = row;
		s.known.last = 1'b1;
		s.known.err = err;
		return s;
	endfunction

	function automatic script_step_t geometry_step(input logic [15:0] w, input logic [15:0] lb,
			input logic [15:0] h);
		script_step_t s;
		s = byte_step('0, 1'b0);
		s.kind = STEP_GEOMETRY;
		s.width = w;
		s.lbytes = lb;
		s.height = h;
		return s;
	endfunction

	initial begin : stimulus
		script_step_t script[$];
		int          phase;
		int          span;
		int          k;
		int          pick;
		int          w;
		int          lb;
		int          h;
		logic [5:0]  cnt;
		bit          last_one;

		// 1x1x1 image after reset: one literal fills it, the rest is ignored
		script.push_back(known_step(8'h00, 1'b0, 8'h00, 16'd0, 16'd0, 1'b0));
		script.push_back(byte_step(8'hFF, 1'b1));
		// 4 visible of 6 bytes per line, two rows
		script.push_back(geometry_step(16'd4, 16'd6, 16'd2));
		script.push_back(byte_step(8'h3F, 1'b0));
		script.push_back(byte_step(8'hBF, 1'b0));
		script.push_back(byte_step(8'h7F, 1'b0));
		// zero-count run swallows its value byte
		script.push_back(byte_step(8'hC0, 1'b0));
		script.push_back(byte_step(8'h55, 1'b0));
		// run of 3 with a marker-looking value, two land in padding
		script.push_back(byte_step(8'hC3, 1'b0));
		script.push_back(byte_step(8'hC1, 1'b0));
		// longest run gets cut at the end of the line, completing the image
		script.push_back(byte_step(8'hFF, 1'b0));
		script.push_back(byte_step(8'hAA, 1'b0));
		// image complete: literal and a final marker both ignored
		script.push_back(byte_step(8'h12, 1'b0));
		script.push_back(byte_step(8'hC5, 1'b1));
		// file ending on a marker
		script.push_back(known_step(8'hC7, 1'b1, 8'h00, 16'd0, 16'd0, 1'b1));
		// shrink the line under the current position mid-row
		script.push_back(byte_step(8'h01, 1'b0));
		script.push_back(byte_step(8'h02, 1'b0));
		script.push_back(byte_step(8'h03, 1'b0));
		script.push_back(geometry_step(16'd4, 16'd2, 16'd2));
		script.push_back(byte_step(8'h04, 1'b0));
		script.push_back(byte_step(8'h05, 1'b0));
		script.push_back(byte_step(8'h06, 1'b1));
		// largest geometry with a full-length run
		script.push_back(geometry_step(16'hFFFF, 16'hFFFF, 16'hFFFF));
		script.push_back(byte_step(8'hFF, 1'b0));
		script.push_back(byte_step(8'hFF, 1'b0));
		script.push_back(known_step(8'h80, 1'b1, 8'h80, 16'd63, 16'd0, 1'b0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == STEP_GEOMETRY) begin
				settle();
				set_geometry(script[i].width, script[i].lbytes, script[i].height);
			end else begin
				send_byte(script[i].data, script[i].eod, script[i].typed, script[i].known);
			end
		end

		// random images: mostly literals and marker/value pairs, some noise and cut files
		phase = 0;
		while (bytes_sent < 120) begin
			settle();
			no_idle = (phase == 2 || phase == 3);
			w = $urandom_range(1, 8);
			if ($urandom_range(7) == 0)
				w = $urandom_range(9, 65535);
			lb = ($urandom_range(3) == 0) ? $urandom_range(1, w) : w + $urandom_range(0, 3);
			if (lb > 65535)
				lb = 65535;
			h = ($urandom_range(7) == 0) ? 65535 : $urandom_range(1, 4);
			set_geometry(16'(w), 16'(lb), 16'(h));
			// pixel side goes quiet while bytes keep coming, backing up the input
			if (phase == 0)
				hold_left = 300;
			span = $urandom_range(6, 30);
			k = 0;
			while (k < span) begin
				last_one = (k == span - 1);
				pick = $urandom_range(19);
				if (pick < 3) begin
					send_byte(8'($urandom_range(255)), last_one || $urandom_range(9) == 0);
					k++;
				end else if (pick < 11) begin
					send_byte(8'($urandom_range(191)), last_one);
					k++;
				end else begin
					cnt = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
						6'($urandom_range(6));
					if (last_one && $urandom_range(1) == 0) begin
						send_byte(pcxrle_pkg::MARKER_MASK | {2'b00, cnt}, 1'b1);
						k++;
					end else begin
						send_byte(pcxrle_pkg::MARKER_MASK | {2'b00, cnt}, 1'b0);
						send_byte(8'($urandom_range(255)), k + 2 >= span);
						k += 2;
					end
				end
			end
			phase++;
		end
		no_idle = 1'b0;

		settle();
		if (failures == 0)
			$display("pcx_rle_row_decoder regression: pass");
		else
			$display("pcx_rle_row_decoder regression: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_ctrl.sv
rtl/core/pcxrle_datapath.sv
rtl/core/pcx_rle_row_decoder.sv
tb/pcx_rle_row_decoder_test.sv
